FILE: rtl/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types and constants of the stack permutation checker: sizes, record
// and register codes, request payloads and the shift controls of the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package spc_pkg;

  // stack and value sizes
  localparam int STACK_DEPTH   = 32;
  localparam int VALUE_BITS    = 16;
  localparam int LEVEL_BITS    = $clog2(STACK_DEPTH + 1);
  localparam int ELEMENT_BITS  = 16;
  localparam int SEQ_LEN_BITS  = 16;
  localparam int CAP_BITS      = 6;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  // register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SEQUENCE_LENGTH = 2'd0,
    REG_STACK_CAPACITY  = 2'd1
  } reg_index_t;

  // output record codes
  typedef enum logic [1:0] {
    REC_POP  = 2'd0,
    REC_PUSH = 2'd1,
    REC_FAIL = 2'd2,
    REC_PASS = 2'd3
  } record_t;

  typedef struct packed {
    logic [ELEMENT_BITS-1:0] element;
    logic                    final_element;
  } spc_in_t;

  typedef struct packed {
    record_t record;
    logic    end_of_burst;
  } spc_out_t;

  // shift controls for the row of cells
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

`default_nettype wire

FILE: rtl/spc_cell.sv
// ----------------------------------------------------------------------------
// spc_cell
// One stack cell: on a push it takes the value of the cell above, on a pop
// the value of the cell below, otherwise it holds.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_cell
  import spc_pkg::*;
(
  input  logic                  clk,
  input  shift_t                shift,
  input  logic [VALUE_BITS-1:0] push_in,
  input  logic [VALUE_BITS-1:0] pop_in,
  output logic [VALUE_BITS-1:0] value
);

  // shift one place toward the bottom or the top
  always_ff @(posedge clk) begin
    if (shift.push) begin
      value <= push_in;
    end else if (shift.pop) begin
      value <= pop_in;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/spc_ctrl.sv
// ----------------------------------------------------------------------------
// spc_ctrl
// Sequencer of the checker: occupancy count, down-counter, overflow flag,
// configuration registers and the registered output record.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_ctrl
  import spc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  spc_in_t                  in_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output spc_out_t                 out_item,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_value,
  input  logic [VALUE_BITS-1:0]    top1,
  output shift_t                   shift,
  output logic [VALUE_BITS-1:0]    push_data
);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_POP     = 3'b010,
    ST_VERDICT = 3'b100
  } state_t;

  state_t                  state, state_next;
  logic [LEVEL_BITS-1:0]   level, level_next;
  logic [VALUE_BITS-1:0]   expected, expected_next;
  logic                    overflowed, overflowed_next;
  logic                    fin, fin_next;
  logic [SEQ_LEN_BITS-1:0] seq_len;
  logic [CAP_BITS-1:0]     capacity;

  logic                    out_free;
  logic                    emit;
  spc_out_t                emit_item;
  logic [CAP_BITS-1:0]     cap_eff;
  logic                    full;
  logic                    elem_match;
  logic                    next_match;
  logic [VALUE_BITS-1:0]   expected_dec;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE) && out_free;
  assign push_data = VALUE_BITS'(in_item.element);

  // effective capacity and lookahead compares
  assign cap_eff      = (capacity < CAP_BITS'(STACK_DEPTH)) ? capacity
                                                            : CAP_BITS'(STACK_DEPTH);
  assign full         = CAP_BITS'(level) >= cap_eff;
  assign elem_match   = push_data == expected;
  assign expected_dec = expected - 1'b1;
  assign next_match   = (level > LEVEL_BITS'(1)) && (top1 == expected_dec);

  // sequencer
  always_comb begin
    state_next      = state;
    level_next      = level;
    expected_next   = expected;
    overflowed_next = overflowed;
    fin_next        = fin;
    shift           = '0;
    emit            = 1'b0;
    emit_item       = '{record: REC_POP, end_of_burst: 1'b0};
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          fin_next   = in_item.final_element;
          state_next = in_item.final_element ? ST_VERDICT : ST_IDLE;
          if (!overflowed) begin
            if (full) begin
              overflowed_next = 1'b1;
            end else begin
              shift.push             = 1'b1;
              level_next             = LEVEL_BITS'(level + 1'b1);
              emit                   = 1'b1;
              emit_item.record       = REC_POP;
              emit_item.end_of_burst = !in_item.final_element && !elem_match;
              if (elem_match) begin
                state_next = ST_POP;
              end
            end
          end
        end
      end
      ST_POP: begin
        // top matches the counter on entry
        if (out_free) begin
          shift.pop              = 1'b1;
          level_next             = LEVEL_BITS'(level - 1'b1);
          expected_next          = expected_dec;
          emit                   = 1'b1;
          emit_item.record       = REC_PUSH;
          emit_item.end_of_burst = !fin && !next_match;
          if (next_match) begin
            state_next = ST_POP;
          end else begin
            state_next = fin ? ST_VERDICT : ST_IDLE;
          end
        end
      end
      ST_VERDICT: begin
        if (out_free) begin
          emit                   = 1'b1;
          emit_item.record       = (!overflowed && level == '0) ? REC_PASS : REC_FAIL;
          emit_item.end_of_burst = 1'b1;
          level_next             = '0;
          overflowed_next        = 1'b0;
          expected_next          = VALUE_BITS'(seq_len);
          state_next             = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // writing the length reloads the counter
    if (cfg_valid && cfg_ready && cfg_index == REG_SEQUENCE_LENGTH) begin
      expected_next = VALUE_BITS'(cfg_value[SEQ_LEN_BITS-1:0]);
    end
  end

  // control registers and configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      level      <= '0;
      overflowed <= 1'b0;
      fin        <= 1'b0;
      out_valid  <= 1'b0;
      seq_len    <= SEQ_LEN_BITS'(1);
      capacity   <= CAP_BITS'(32);
      expected   <= VALUE_BITS'(1);
    end else begin
      state      <= state_next;
      level      <= level_next;
      overflowed <= overflowed_next;
      fin        <= fin_next;
      expected   <= expected_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_SEQUENCE_LENGTH: begin
            seq_len <= cfg_value[SEQ_LEN_BITS-1:0];
          end
          REG_STACK_CAPACITY: begin
            capacity <= cfg_value[CAP_BITS-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // output record payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_item <= emit_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/stack_permutation_checker.sv
// ----------------------------------------------------------------------------
// stack_permutation_checker
// Checks whether a target order can be produced through one bounded stack
// and emits the push and pop records of that production, last one first.
// ----------------------------------------------------------------------------
// Elements come in from the last target position to the first. Each accepted
// element, when pushed, yields a pop record; every following match of the
// top against the down-counter yields a push record; an element marked final
// then yields a verdict record. The stack is a row of shift cells, and the
// lookahead compares the second cell against the counter less one. A new
// element is taken only once the previous one's records have all been
// issued; a stalled output stalls the sequencer. The stack needs no clearing
// after reset.
`default_nettype none

module stack_permutation_checker
  import spc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  spc_in_t                  in_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output spc_out_t                 out_item,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_value
);

  shift_t                shift;
  logic [VALUE_BITS-1:0] push_data;
  logic [VALUE_BITS-1:0] cell_val [STACK_DEPTH];
  logic [VALUE_BITS-1:0] top1;

  // sequencer
  spc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_value (cfg_value),
    .top1      (top1),
    .shift     (shift),
    .push_data (push_data)
  );

  // second entry from the top, for the lookahead compare
  generate
    if (STACK_DEPTH > 1) begin : g_top1
      assign top1 = cell_val[1];
    end else begin : g_no_top1
      assign top1 = '0;
    end
  endgenerate

  // row of stack cells, top at index zero
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [VALUE_BITS-1:0] push_in;
    logic [VALUE_BITS-1:0] pop_in;

    if (i == 0) begin : g_head
      assign push_in = push_data;
    end else begin : g_body
      assign push_in = cell_val[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_tail
      assign pop_in = '0;
    end else begin : g_inner
      assign pop_in = cell_val[i+1];
    end

    spc_cell u_cell (
      .clk     (clk),
      .shift   (shift),
      .push_in (push_in),
      .pop_in  (pop_in),
      .value   (cell_val[i])
    );
  end

endmodule

`default_nettype wire
